### hdl/tss_pkg.sv
// shared types, constants and helpers for the tridiagonal solver
`default_nettype none
package tss_pkg;

  localparam int DATA_W        = 32;
  localparam int PROD_W        = 64;
  localparam int IDX_W         = 6;
  localparam int DEF_MAX_ROWS  = 64;
  localparam int DEF_FRAC_BITS = 16;

  localparam logic signed [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  typedef struct packed {
    logic load_in;
    logic rd_fwd;
    logic mul_up;
    logic mul_rhs;
    logic div_fwd;
    logic save_q1;
    logic save_q2;
    logic wr_fwd;
    logic rd_back;
    logic mul_back;
    logic div_back;
    logic wr_back;
    logic rd_sol;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic cnt_zero;
    logic solve_now;
    logic div_done;
    logic k_zero;
    logic out_free;
  } sts_t;

  function automatic logic signed [DATA_W-1:0] sat_sub(
    input logic signed [DATA_W-1:0] a,
    input logic signed [DATA_W-1:0] b
  );
    logic signed [DATA_W:0] d;
    d = (DATA_W+1)'(a) - (DATA_W+1)'(b);
    if (d > (DATA_W+1)'(SAT_MAX)) return SAT_MAX;
    if (d < (DATA_W+1)'(SAT_MIN)) return SAT_MIN;
    return d[DATA_W-1:0];
  endfunction

endpackage
`default_nettype wire

### hdl/tss_div.sv
// bit-serial signed 64 by 32 divider with saturating quotient
`default_nettype none
module tss_div (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 start,
  input  wire logic signed [tss_pkg::PROD_W-1:0]    num,
  input  wire logic signed [tss_pkg::DATA_W-1:0]    den,
  output logic                                      done,
  output logic signed [tss_pkg::DATA_W-1:0]         quot,
  output logic                                      den_zero
);
  import tss_pkg::*;

  localparam int SW = $clog2(PROD_W);
  localparam logic [PROD_W-1:0] POS_LIM = PROD_W'(SAT_MAX);
  localparam logic [PROD_W-1:0] NEG_LIM = PROD_W'(SAT_MAX) + PROD_W'(1);

  logic                busy_r, busy_nxt;
  logic                fin_r, fin_nxt;
  logic                done_r, done_nxt;
  logic [SW-1:0]       step_r, step_nxt;
  logic [DATA_W:0]     rem_r, rem_nxt;
  logic [PROD_W-1:0]   quo_r, quo_nxt;
  logic [DATA_W-1:0]   ud_r, ud_nxt;
  logic                neg_r, neg_nxt;
  logic signed [DATA_W-1:0] q_r, q_nxt;
  logic                dz_r, dz_nxt;
  logic [DATA_W:0]     rem_sh;

  always_comb begin
    busy_nxt = busy_r;
    fin_nxt  = 1'b0;
    done_nxt = 1'b0;
    step_nxt = step_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    ud_nxt   = ud_r;
    neg_nxt  = neg_r;
    q_nxt    = q_r;
    dz_nxt   = dz_r;
    rem_sh   = {rem_r[DATA_W-1:0], quo_r[PROD_W-1]};
    if (start) begin
      dz_nxt = 1'b0;
      if (den == '0) begin
        dz_nxt   = 1'b1;
        done_nxt = 1'b1;
        if (num > 0) q_nxt = SAT_MAX;
        else if (num < 0) q_nxt = SAT_MIN;
        else q_nxt = '0;
      end else begin
        busy_nxt = 1'b1;
        step_nxt = '0;
        rem_nxt  = '0;
        quo_nxt  = num[PROD_W-1] ? PROD_W'(-num) : PROD_W'(num);
        ud_nxt   = den[DATA_W-1] ? DATA_W'(-den) : DATA_W'(den);
        neg_nxt  = num[PROD_W-1] ^ den[DATA_W-1];
      end
    end else if (busy_r) begin
      if (rem_sh >= {1'b0, ud_r}) begin
        rem_nxt = rem_sh - {1'b0, ud_r};
        quo_nxt = {quo_r[PROD_W-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh;
        quo_nxt = {quo_r[PROD_W-2:0], 1'b0};
      end
      step_nxt = step_r + SW'(1);
      if (step_r == SW'(PROD_W-1)) begin
        busy_nxt = 1'b0;
        fin_nxt  = 1'b1;
      end
    end else if (fin_r) begin
      done_nxt = 1'b1;
      if (neg_r) begin
        if (quo_r > NEG_LIM) q_nxt = SAT_MIN;
        else q_nxt = -$signed(quo_r[DATA_W-1:0]);
      end else begin
        if (quo_r > POS_LIM) q_nxt = SAT_MAX;
        else q_nxt = $signed(quo_r[DATA_W-1:0]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      fin_r  <= fin_nxt;
      done_r <= done_nxt;
    end
    step_r <= step_nxt;
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
    ud_r   <= ud_nxt;
    neg_r  <= neg_nxt;
    q_r    <= q_nxt;
    dz_r   <= dz_nxt;
  end

  assign done     = done_r;
  assign quot     = q_r;
  assign den_zero = dz_r;
endmodule
`default_nettype wire

### hdl/tss_dp.sv
// solver datapath: row stores, multiplier, divider and result register
`default_nettype none
module tss_dp #(
  parameter int MAX_ROWS  = tss_pkg::DEF_MAX_ROWS,
  parameter int FRAC_BITS = tss_pkg::DEF_FRAC_BITS
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire tss_pkg::cmd_t                      cmd,
  output tss_pkg::sts_t                           sts,
  input  wire logic signed [tss_pkg::DATA_W-1:0]  in_lower_coef,
  input  wire logic signed [tss_pkg::DATA_W-1:0]  in_diag_coef,
  input  wire logic signed [tss_pkg::DATA_W-1:0]  in_upper_coef,
  input  wire logic signed [tss_pkg::DATA_W-1:0]  in_rhs_value,
  input  wire logic                               in_last_row,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic [tss_pkg::IDX_W-1:0]               out_row_index,
  output logic signed [tss_pkg::DATA_W-1:0]       out_solution_value,
  output logic                                    out_last_result,
  output logic                                    out_pivot_zero
);
  import tss_pkg::*;

  localparam int IW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW = $clog2(MAX_ROWS + 1);

  logic signed [DATA_W-1:0] a_r, b_r, c_r, y_r;
  logic                     last_r;
  logic signed [DATA_W-1:0] lower_r, x_r, q1_r, q2_r;
  logic [CW-1:0]            cnt_r;
  logic [IW-1:0]            k_r;
  logic                     first_r, zp_r;
  logic signed [DATA_W-1:0] pv_rd_r, up_rd_r, rh_rd_r, sol_rd_r;
  logic signed [PROD_W-1:0] prod_r;

  logic signed [DATA_W-1:0] pivot_mem [MAX_ROWS];
  logic signed [DATA_W-1:0] upper_mem [MAX_ROWS];
  logic signed [DATA_W-1:0] rhs_mem   [MAX_ROWS];
  logic signed [DATA_W-1:0] sol_mem   [MAX_ROWS];

  logic                     out_valid_r;
  logic [IDX_W-1:0]         out_idx_r;
  logic signed [DATA_W-1:0] out_val_r;
  logic                     out_last_r, out_pz_r;

  logic [IW-1:0]            i_idx, rd_addr;
  logic [CW-1:0]            cnt_m1;
  logic                     rd_en, clear;
  logic signed [DATA_W-1:0] pivot_wd, rhs_wd;
  logic signed [PROD_W-1:0] rh_ext, back_num;
  logic                     div_start, div_done, div_dz;
  logic signed [PROD_W-1:0] div_num;
  logic signed [DATA_W-1:0] div_q;

  assign i_idx    = cnt_r[IW-1:0];
  assign cnt_m1   = cnt_r - CW'(1);
  assign rd_en    = cmd.rd_fwd | cmd.rd_back;
  assign rd_addr  = cmd.rd_fwd ? (i_idx - IW'(1)) : k_r;
  assign pivot_wd = (cnt_r == '0) ? b_r : sat_sub(b_r, q1_r);
  assign rhs_wd   = (cnt_r == '0) ? y_r : sat_sub(y_r, q2_r);
  assign rh_ext   = PROD_W'(rh_rd_r);
  assign back_num = (rh_ext <<< FRAC_BITS) - (first_r ? PROD_W'(0) : prod_r);
  assign div_start = cmd.div_fwd | cmd.div_back;
  assign div_num   = cmd.div_back ? back_num : prod_r;
  assign clear     = cmd.load_out & (k_r == '0);

  tss_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .num      (div_num),
    .den      (pv_rd_r),
    .done     (div_done),
    .quot     (div_q),
    .den_zero (div_dz)
  );

  always_ff @(posedge clk) begin
    if (cmd.wr_fwd) pivot_mem[i_idx] <= pivot_wd;
    if (rd_en) pv_rd_r <= pivot_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_fwd) upper_mem[i_idx] <= c_r;
    if (rd_en) up_rd_r <= upper_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_fwd) rhs_mem[i_idx] <= rhs_wd;
    if (rd_en) rh_rd_r <= rhs_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_back && div_done) sol_mem[k_r] <= div_q;
    if (cmd.rd_sol) sol_rd_r <= sol_mem[k_r];
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      a_r    <= in_lower_coef;
      b_r    <= in_diag_coef;
      c_r    <= in_upper_coef;
      y_r    <= in_rhs_value;
      last_r <= in_last_row;
    end
    if (cmd.mul_up)   prod_r <= PROD_W'(lower_r) * PROD_W'(up_rd_r);
    if (cmd.mul_rhs)  prod_r <= PROD_W'(lower_r) * PROD_W'(rh_rd_r);
    if (cmd.mul_back) prod_r <= PROD_W'(up_rd_r) * PROD_W'(x_r);
    if (cmd.save_q1 && div_done) q1_r <= div_q;
    if (cmd.save_q2 && div_done) q2_r <= div_q;
    if (cmd.load_out) begin
      out_idx_r  <= IDX_W'(k_r);
      out_val_r  <= sol_rd_r;
      out_last_r <= (k_r == '0);
      out_pz_r   <= zp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lower_r     <= '0;
      cnt_r       <= '0;
      x_r         <= '0;
      zp_r        <= 1'b0;
      k_r         <= '0;
      first_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.wr_fwd) begin
        lower_r <= a_r;
        cnt_r   <= cnt_r + CW'(1);
        k_r     <= i_idx;
        first_r <= 1'b1;
      end
      if (cmd.wr_back && div_done) begin
        x_r     <= div_q;
        first_r <= 1'b0;
        k_r     <= (k_r == '0) ? cnt_m1[IW-1:0] : k_r - IW'(1);
      end
      if (div_done && div_dz) zp_r <= 1'b1;
      if (cmd.load_out) k_r <= k_r - IW'(1);
      if (clear) begin
        lower_r <= '0;
        cnt_r   <= '0;
        x_r     <= '0;
        zp_r    <= 1'b0;
      end
      if (cmd.load_out) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  assign sts.cnt_zero  = (cnt_r == '0);
  assign sts.solve_now = last_r | (cnt_r == CW'(MAX_ROWS - 1));
  assign sts.div_done  = div_done;
  assign sts.k_zero    = (k_r == '0);
  assign sts.out_free  = ~out_valid_r | out_ready;

  assign out_valid          = out_valid_r;
  assign out_row_index      = out_idx_r;
  assign out_solution_value = out_val_r;
  assign out_last_result    = out_last_r;
  assign out_pivot_zero     = out_pz_r;
endmodule
`default_nettype wire

### hdl/tss_ctrl.sv
// solver sequencer: forward elimination, back sweep and result drain
`default_nettype none
module tss_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire tss_pkg::sts_t  sts,
  output tss_pkg::cmd_t       cmd
);
  import tss_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_FRD   = 4'd1;
  localparam logic [3:0] S_FMUL1 = 4'd2;
  localparam logic [3:0] S_FDIV1 = 4'd3;
  localparam logic [3:0] S_FW1   = 4'd4;
  localparam logic [3:0] S_FMUL2 = 4'd5;
  localparam logic [3:0] S_FDIV2 = 4'd6;
  localparam logic [3:0] S_FW2   = 4'd7;
  localparam logic [3:0] S_FWR   = 4'd8;
  localparam logic [3:0] S_BRD   = 4'd9;
  localparam logic [3:0] S_BMUL  = 4'd10;
  localparam logic [3:0] S_BDIV  = 4'd11;
  localparam logic [3:0] S_BW    = 4'd12;
  localparam logic [3:0] S_ORD   = 4'd13;
  localparam logic [3:0] S_OLD   = 4'd14;

  logic [3:0] state_r, state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = sts.cnt_zero ? S_FWR : S_FRD;
        end
      end
      S_FRD: begin
        cmd.rd_fwd = 1'b1;
        state_nxt  = S_FMUL1;
      end
      S_FMUL1: begin
        cmd.mul_up = 1'b1;
        state_nxt  = S_FDIV1;
      end
      S_FDIV1: begin
        cmd.div_fwd = 1'b1;
        state_nxt   = S_FW1;
      end
      S_FW1: begin
        cmd.save_q1 = 1'b1;
        if (sts.div_done) state_nxt = S_FMUL2;
      end
      S_FMUL2: begin
        cmd.mul_rhs = 1'b1;
        state_nxt   = S_FDIV2;
      end
      S_FDIV2: begin
        cmd.div_fwd = 1'b1;
        state_nxt   = S_FW2;
      end
      S_FW2: begin
        cmd.save_q2 = 1'b1;
        if (sts.div_done) state_nxt = S_FWR;
      end
      S_FWR: begin
        cmd.wr_fwd = 1'b1;
        state_nxt  = sts.solve_now ? S_BRD : S_IDLE;
      end
      S_BRD: begin
        cmd.rd_back = 1'b1;
        state_nxt   = S_BMUL;
      end
      S_BMUL: begin
        cmd.mul_back = 1'b1;
        state_nxt    = S_BDIV;
      end
      S_BDIV: begin
        cmd.div_back = 1'b1;
        state_nxt    = S_BW;
      end
      S_BW: begin
        cmd.wr_back = 1'b1;
        if (sts.div_done) state_nxt = sts.k_zero ? S_ORD : S_BRD;
      end
      S_ORD: begin
        cmd.rd_sol = 1'b1;
        state_nxt  = S_OLD;
      end
      S_OLD: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = sts.k_zero ? S_IDLE : S_ORD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

  assign in_ready = (state_r == S_IDLE);
endmodule
`default_nettype wire

### hdl/tridiagonal_system_solver_unit.sv
// top level of the fixed point tridiagonal solver
//
//   channel  direction  payload
//   in_*     request in lower_coef, diag_coef, upper_coef, rhs_value, last_row
//   out_*    result out row_index, solution_value, last_result, pivot_zero
//
// row 0 is stored directly; each later row is set by two serial
// divides in the one shared bit-serial divider
// a solve of n rows then runs the back sweep with one serial divide per row,
// followed by the results one row at a time, which wait while out_ready is low
// reset clears control state, counters, flags and some working registers; row stores are not cleared
// the result register lets a new request enter while the last result waits
`default_nettype none
module tridiagonal_system_solver_unit #(
  parameter int MAX_ROWS  = tss_pkg::DEF_MAX_ROWS,
  parameter int FRAC_BITS = tss_pkg::DEF_FRAC_BITS
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic signed [tss_pkg::DATA_W-1:0]  in_lower_coef,
  input  wire logic signed [tss_pkg::DATA_W-1:0]  in_diag_coef,
  input  wire logic signed [tss_pkg::DATA_W-1:0]  in_upper_coef,
  input  wire logic signed [tss_pkg::DATA_W-1:0]  in_rhs_value,
  input  wire logic                               in_last_row,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic [tss_pkg::IDX_W-1:0]               out_row_index,
  output logic signed [tss_pkg::DATA_W-1:0]       out_solution_value,
  output logic                                    out_last_result,
  output logic                                    out_pivot_zero
);
  import tss_pkg::*;

  cmd_t cmd;
  sts_t sts;

  tss_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  tss_dp #(
    .MAX_ROWS  (MAX_ROWS),
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_lower_coef      (in_lower_coef),
    .in_diag_coef       (in_diag_coef),
    .in_upper_coef      (in_upper_coef),
    .in_rhs_value       (in_rhs_value),
    .in_last_row        (in_last_row),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_row_index      (out_row_index),
    .out_solution_value (out_solution_value),
    .out_last_result    (out_last_result),
    .out_pivot_zero     (out_pivot_zero)
  );
endmodule
`default_nettype wire
